>>> hw/rtl/wavetable_sample_generator_top_macros.svh
// Assertion macros for the wavetable sample generator.
// Taken in by the top level; depends on nothing else.
`ifndef WAVETABLE_SAMPLE_GENERATOR_TOP_MACROS_SVH
`define WAVETABLE_SAMPLE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define WTSG_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");
// Next-cycle implication.
`define WTSG_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");
`else
`define WTSG_ASSERT_NOW(lbl, ck, rstn, ante, cons)
`define WTSG_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/wtsg_pkg.sv
// Shared types, constants and the CORDIC angle table of the wavetable
// sample generator. No dependencies.
package wtsg_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int MAX_TABLE_SIZE    = 4096;
    localparam int INDEX_BITS        = 12;
    localparam int SIZE_BITS         = 13;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 13;

    localparam int DIV_LO_BITS       = 32;
    localparam int DIV_STEP_BITS     = 6;
    localparam logic [DIV_STEP_BITS-1:0] SINE_DIV_STEPS = 6'd32;
    localparam logic [DIV_STEP_BITS-1:0] SAW_DIV_STEPS  = 6'd16;
    localparam logic [DIV_STEP_BITS-1:0] TRI_DIV_STEPS  = 6'd17;

    localparam int CORDIC_STEPS      = 24;
    localparam int CORDIC_STEP_BITS  = 5;
    localparam int CORDIC_BITS       = 32;
    localparam int CORDIC_SCALE_BITS = 30;
    localparam int ANGLE_BITS        = 31;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN_INV = 32'sd652032874;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_SIZE = 2'd1;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_SAW      = 2'd2,
        SHAPE_TRIANGLE = 2'd3
    } shape_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_ROTATE = 2'd2
    } state_t;

    typedef struct packed {
        logic                      start;
        logic [DIV_STEP_BITS-1:0]  steps;
        logic [SIZE_BITS-1:0]      divisor;
        logic [SIZE_BITS-1:0]      rem_init;
        logic [DIV_LO_BITS-1:0]    lo;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic [DIV_LO_BITS-1:0]    quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                      start;
        logic [ANGLE_BITS-1:0]     angle;
    } cordic_req_t;

    typedef struct packed {
        logic                            done;
        logic signed [CORDIC_BITS-1:0]   y;
    } cordic_rsp_t;

    // atan(2^-k) in units of 2^32 per turn
    function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [CORDIC_STEP_BITS-1:0] k);
        logic [ANGLE_BITS-1:0] a;
        unique case (k)
            5'd0:    a = 31'd536870912;
            5'd1:    a = 31'd316933406;
            5'd2:    a = 31'd167458907;
            5'd3:    a = 31'd85004756;
            5'd4:    a = 31'd42667331;
            5'd5:    a = 31'd21354465;
            5'd6:    a = 31'd10679838;
            5'd7:    a = 31'd5340245;
            5'd8:    a = 31'd2670163;
            5'd9:    a = 31'd1335087;
            5'd10:   a = 31'd667544;
            5'd11:   a = 31'd333772;
            5'd12:   a = 31'd166886;
            5'd13:   a = 31'd83443;
            5'd14:   a = 31'd41722;
            5'd15:   a = 31'd20861;
            5'd16:   a = 31'd10430;
            5'd17:   a = 31'd5215;
            5'd18:   a = 31'd2608;
            5'd19:   a = 31'd1304;
            5'd20:   a = 31'd652;
            5'd21:   a = 31'd326;
            5'd22:   a = 31'd163;
            5'd23:   a = 31'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/wtsg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wtsg_pkg.
module wtsg_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  wtsg_pkg::div_req_t  req,
    output wtsg_pkg::div_rsp_t  rsp
);

    logic [wtsg_pkg::SIZE_BITS-1:0]     rem_reg, rem_next;
    logic [wtsg_pkg::SIZE_BITS-1:0]     div_reg;
    logic [wtsg_pkg::DIV_LO_BITS-1:0]   lo_reg, lo_next;
    logic [wtsg_pkg::DIV_LO_BITS-1:0]   q_reg, q_next;
    logic [wtsg_pkg::DIV_STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                               run_reg, run_next;
    logic                               done_reg, done_next;
    logic [wtsg_pkg::SIZE_BITS:0]       shifted;
    logic [wtsg_pkg::SIZE_BITS:0]       diff;
    logic                               ge;

    // remainder stays below the divisor, so one extra bit holds the shifted value
    assign shifted = {rem_reg, lo_reg[wtsg_pkg::DIV_LO_BITS-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.rem_init;
            lo_next  = req.lo;
            q_next   = '0;
            cnt_next = req.steps;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[wtsg_pkg::SIZE_BITS-1:0] : shifted[wtsg_pkg::SIZE_BITS-1:0];
            lo_next  = {lo_reg[wtsg_pkg::DIV_LO_BITS-2:0], 1'b0};
            q_next   = {q_reg[wtsg_pkg::DIV_LO_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        if (req.start)
        begin
            div_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

>>> hw/rtl/wtsg_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on wtsg_pkg.
module wtsg_cordic
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wtsg_pkg::cordic_req_t  req,
    output wtsg_pkg::cordic_rsp_t  rsp
);

    logic signed [wtsg_pkg::CORDIC_BITS-1:0]   x_reg, x_next;
    logic signed [wtsg_pkg::CORDIC_BITS-1:0]   y_reg, y_next;
    logic signed [wtsg_pkg::CORDIC_BITS-1:0]   z_reg, z_next;
    logic signed [wtsg_pkg::CORDIC_BITS-1:0]   dx, dy, da;
    logic [wtsg_pkg::CORDIC_STEP_BITS-1:0]     k_reg, k_next;
    logic                                      run_reg, run_next;
    logic                                      done_reg, done_next;

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign da = $signed({1'b0, wtsg_pkg::atan_turn(k_reg)});

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next   = wtsg_pkg::CORDIC_GAIN_INV;
            y_next   = '0;
            z_next   = $signed({1'b0, req.angle});
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // rotate toward zero residual angle
            if (!z_reg[wtsg_pkg::CORDIC_BITS-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            k_next = k_reg + 1'b1;
            if (k_reg == 5'(wtsg_pkg::CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule

>>> hw/rtl/wavetable_sample_generator_top.sv
// Wavetable sample generator, top level: registers, sequencer, result word.
// Depends on wtsg_pkg, wtsg_div, wtsg_cordic and the assertion macro header.
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  --------------------------
//  config    cfg_we, cfg_index, cfg_data            write when cfg_we is high
//  request   start, sample_index, busy              taken on start && !busy
//  result    done, sample_value, index_out_of_range one-cycle strobe on done
//
// Per word: a square or out-of-range index uses no arithmetic unit; saw
// and triangle use one restoring divider bit per cycle, plus handoff;
// sine divides for the phase, then runs 24 CORDIC rotations. busy is
// high for the whole computation; a new word may be taken in the cycle
// that shows done. Reset clears control state and the registers to sine
// shape with 1024 entries. The result side cannot stall: each done word
// is shown for exactly one cycle.
`include "wavetable_sample_generator_top_macros.svh"

module wavetable_sample_generator_top
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [wtsg_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [wtsg_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                      start,
    input  logic [wtsg_pkg::INDEX_BITS-1:0]           sample_index,
    output logic                                      busy,
    output logic                                      done,
    output logic signed [wtsg_pkg::SAMPLE_BITS-1:0]   sample_value,
    output logic                                      index_out_of_range
);

    localparam logic signed [wtsg_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [wtsg_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = -16'sd32768;

    // Saturate a wide signed intermediate into the sample range.
    function automatic logic signed [wtsg_pkg::SAMPLE_BITS-1:0] sat_sample(
        input logic signed [18:0] v);
        logic signed [wtsg_pkg::SAMPLE_BITS-1:0] r;
        if (v > 19'sd32767)
        begin
            r = SAMPLE_MAX;
        end
        else if (v < -19'sd32768)
        begin
            r = SAMPLE_MIN;
        end
        else
        begin
            r = v[wtsg_pkg::SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    // configuration registers
    wtsg_pkg::shape_t                      wave_shape_reg;
    logic [wtsg_pkg::SIZE_BITS-1:0]        table_size_reg;

    // sequencer and per-word context
    wtsg_pkg::state_t                      state_reg, state_next;
    wtsg_pkg::shape_t                      shape_reg;
    logic                                  lower_reg;
    logic                                  neg_reg;

    // result word
    logic signed [wtsg_pkg::SAMPLE_BITS-1:0] sample_value_reg, sample_value_next;
    logic                                  flag_reg, flag_next;
    logic                                  done_reg, done_next;

    // request decode
    logic                                  accept;
    logic [wtsg_pkg::SIZE_BITS-1:0]        size_eff;
    logic [wtsg_pkg::SIZE_BITS-1:0]        half_size;
    logic [wtsg_pkg::SIZE_BITS-1:0]        index_ext;
    logic                                  out_of_range;
    logic                                  immediate;
    logic signed [wtsg_pkg::SAMPLE_BITS-1:0] square_value;

    // arithmetic units
    wtsg_pkg::div_req_t                    div_req;
    wtsg_pkg::div_rsp_t                    div_rsp;
    wtsg_pkg::cordic_req_t                 cordic_req;
    wtsg_pkg::cordic_rsp_t                 cordic_rsp;

    // result formatting
    logic [31:0]                           phase_mag;
    logic [31:0]                           phase_fold;
    logic [16:0]                           ratio;
    logic signed [18:0]                    saw_wide;
    logic signed [18:0]                    tri_wide;
    logic [30:0]                           y_pos;
    logic [31:0]                           y_round;
    logic [16:0]                           mag_wide;
    logic signed [wtsg_pkg::SAMPLE_BITS-1:0] mag;
    logic signed [wtsg_pkg::SAMPLE_BITS-1:0] sine_value;

    //------------------------------------------------------------------
    // Configuration: plain write port, unknown indexes drop silently.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= wtsg_pkg::SHAPE_SINE;
            table_size_reg <= 13'd1024;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wtsg_pkg::REG_WAVE_SHAPE)
            begin
                wave_shape_reg <= wtsg_pkg::shape_t'(cfg_data[1:0]);
            end
            else if (cfg_index == wtsg_pkg::REG_TABLE_SIZE)
            begin
                table_size_reg <= cfg_data;
            end
        end
    end

    //------------------------------------------------------------------
    // Request decode. Oversized tables clamp to the maximum size.
    //------------------------------------------------------------------
    assign accept    = start && (state_reg == wtsg_pkg::ST_IDLE);
    assign size_eff  = (table_size_reg > 13'(wtsg_pkg::MAX_TABLE_SIZE))
                     ? 13'(wtsg_pkg::MAX_TABLE_SIZE) : table_size_reg;
    assign half_size = size_eff >> 1;
    assign index_ext = {1'b0, sample_index};
    assign out_of_range = index_ext >= size_eff;
    assign immediate = out_of_range || (wave_shape_reg == wtsg_pkg::SHAPE_SQUARE);

    // Square: zero at both ends, +1 in the lower half, -1 above.
    always_comb
    begin
        if ((index_ext == '0) || (index_ext == size_eff - 1'b1))
        begin
            square_value = '0;
        end
        else if (index_ext < half_size)
        begin
            square_value = SAMPLE_MAX;
        end
        else
        begin
            square_value = SAMPLE_MIN;
        end
    end

    //------------------------------------------------------------------
    // Divider request. Dividend is index * 2^n + divisor/2 for rounding;
    // the low part is left-aligned so n steps shift it in MSB first.
    //------------------------------------------------------------------
    always_comb
    begin
        div_req          = '0;
        div_req.start    = accept && !immediate;
        div_req.rem_init = index_ext;
        unique case (wave_shape_reg)
            wtsg_pkg::SHAPE_SINE:
            begin
                div_req.steps   = wtsg_pkg::SINE_DIV_STEPS;
                div_req.divisor = size_eff + 1'b1;
                div_req.lo      = 32'(div_req.divisor >> 1);
            end
            wtsg_pkg::SHAPE_SAW:
            begin
                div_req.steps   = wtsg_pkg::SAW_DIV_STEPS;
                div_req.divisor = size_eff;
                div_req.lo      = 32'(half_size) << 16;
            end
            wtsg_pkg::SHAPE_TRIANGLE:
            begin
                div_req.steps   = wtsg_pkg::TRI_DIV_STEPS;
                div_req.divisor = size_eff;
                div_req.lo      = 32'(half_size) << 15;
            end
            default:
            begin
                div_req.steps   = wtsg_pkg::SAW_DIV_STEPS;
                div_req.divisor = size_eff;
                div_req.lo      = '0;
            end
        endcase
    end

    wtsg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    //------------------------------------------------------------------
    // Fold the 32-bit phase into the first quarter turn, keep the sign.
    //------------------------------------------------------------------
    assign phase_mag  = {1'b0, div_rsp.quotient[30:0]};
    assign phase_fold = (phase_mag > 32'h4000_0000) ? (32'h8000_0000 - phase_mag) : phase_mag;

    assign cordic_req.start = (state_reg == wtsg_pkg::ST_DIVIDE) && div_rsp.done
                           && (shape_reg == wtsg_pkg::SHAPE_SINE);
    assign cordic_req.angle = phase_fold[30:0];

    wtsg_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    //------------------------------------------------------------------
    // Saw and triangle from the rounded ratio.
    //------------------------------------------------------------------
    assign ratio    = div_rsp.quotient[16:0];
    assign saw_wide = 19'sd32768 - $signed({2'b00, ratio});
    assign tri_wide = lower_reg ? ($signed({2'b00, ratio}) - 19'sd32768)
                                : (19'sd98304 - $signed({2'b00, ratio}));

    // Sine: clamp negative at zero, round half up to Q1.15, saturate, sign.
    assign y_pos      = cordic_rsp.y[31] ? '0 : cordic_rsp.y[30:0];
    assign y_round    = {1'b0, y_pos} + 32'd16384;
    assign mag_wide   = y_round[31:15];
    assign mag        = (mag_wide > 17'd32767) ? SAMPLE_MAX : $signed(mag_wide[15:0]);
    assign sine_value = neg_reg ? -mag : mag;

    //------------------------------------------------------------------
    // Sequencer: next state.
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wtsg_pkg::ST_IDLE:
            begin
                if (accept && !immediate)
                begin
                    state_next = wtsg_pkg::ST_DIVIDE;
                end
            end
            wtsg_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = (shape_reg == wtsg_pkg::SHAPE_SINE)
                               ? wtsg_pkg::ST_ROTATE : wtsg_pkg::ST_IDLE;
                end
            end
            wtsg_pkg::ST_ROTATE:
            begin
                if (cordic_rsp.done)
                begin
                    state_next = wtsg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wtsg_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Sequencer: result word.
    //------------------------------------------------------------------
    always_comb
    begin
        done_next         = 1'b0;
        flag_next         = flag_reg;
        sample_value_next = sample_value_reg;
        unique case (state_reg)
            wtsg_pkg::ST_IDLE:
            begin
                if (accept && immediate)
                begin
                    done_next         = 1'b1;
                    flag_next         = out_of_range;
                    sample_value_next = out_of_range ? '0 : square_value;
                end
            end
            wtsg_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done && (shape_reg != wtsg_pkg::SHAPE_SINE))
                begin
                    done_next         = 1'b1;
                    flag_next         = 1'b0;
                    sample_value_next = (shape_reg == wtsg_pkg::SHAPE_SAW)
                                      ? sat_sample(saw_wide) : sat_sample(tri_wide);
                end
            end
            wtsg_pkg::ST_ROTATE:
            begin
                if (cordic_rsp.done)
                begin
                    done_next         = 1'b1;
                    flag_next         = 1'b0;
                    sample_value_next = sine_value;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtsg_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold per-word context; latch the sign once the phase is known.
    always_ff @(posedge clk)
    begin
        sample_value_reg <= sample_value_next;
        flag_reg         <= flag_next;
        if (accept)
        begin
            shape_reg <= wave_shape_reg;
            lower_reg <= index_ext <= half_size;
        end
        if (cordic_req.start)
        begin
            neg_reg <= div_rsp.quotient[31];
        end
    end

    assign busy               = (state_reg != wtsg_pkg::ST_IDLE);
    assign done               = done_reg;
    assign sample_value       = sample_value_reg;
    assign index_out_of_range = flag_reg;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    `WTSG_ASSERT_NOW(a_done_when_idle, clk, rst_n, done_reg, state_reg == wtsg_pkg::ST_IDLE)
    `WTSG_ASSERT_NOW(a_range_zero, clk, rst_n, done_reg && flag_reg, sample_value_reg == '0)
    `WTSG_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || done_reg)
    `WTSG_ASSERT_NOW(a_rotate_is_sine, clk, rst_n, state_reg == wtsg_pkg::ST_ROTATE, shape_reg == wtsg_pkg::SHAPE_SINE)

endmodule

>>> tb/sv/tb_wavetable_sample_generator_top.sv
// Self-checking testbench for wavetable_sample_generator_top: drives index words,
// predicts every sample word on the fly and checks each done strobe against it.
// Depends on wtsg_pkg and the wavetable_sample_generator_top RTL.
`timescale 1ns / 1ps

module tb_wavetable_sample_generator_top;

    import wtsg_pkg::*;

    // Register indexes beyond the two real ones; writes there must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_3 = 2'd3;

    // Longest word is a sine; the drain at the end runs past it.
    localparam int DRAIN_CYCLES  = 64;
    // Cycles without any accepted word, result or write before giving up.
    localparam int STALL_LIMIT   = 4000;
    localparam int WORDS_RANDOM  = 1600;
    localparam int REPORT_LIMIT  = 10;

    // Rotation angles atan(2^-k) as fractions of 2^32 per turn.
    localparam longint ROT_ANGLE [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          flag;
    } sample_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [CFG_INDEX_BITS-1:0]      cfg_index;
    logic [CFG_DATA_BITS-1:0]       cfg_data;
    logic                           start;
    logic [INDEX_BITS-1:0]          sample_index;
    logic                           busy;
    logic                           done;
    logic signed [SAMPLE_BITS-1:0]  sample_value;
    logic                           index_out_of_range;

    // Predictor copy of the two registers.
    shape_t                         cur_shape;
    logic [SIZE_BITS-1:0]           cur_size;

    sample_word_t                   expected_words[$];
    int                             mismatch_count = 0;
    int                             stall_cycles = 0;
    int                             sender_idle_pct = 0;

    wavetable_sample_generator_top DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .start              (start),
        .sample_index       (sample_index),
        .busy               (busy),
        .done               (done),
        .sample_value       (sample_value),
        .index_out_of_range (index_out_of_range)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate to the signed sample range.
    function automatic longint clamp_q15(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -(longint'(1) << (SAMPLE_BITS - 1));
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Phase as a 32-bit turn, folded into the first quadrant with a sign,
    // then 24 rotations at 2^30 scale and a half-up round to Q1.15.
    function automatic longint sine_cordic(input longint unsigned i,
                                           input longint unsigned size);
        longint unsigned d;
        longint unsigned phase;
        bit              neg;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          mag;
        int              shift;
        d     = size + 1;
        phase = ((i << 32) + d / 2) / d;
        phase = phase & 64'hFFFF_FFFF;
        neg   = 1'b0;
        if (phase >= 64'h8000_0000)
        begin
            phase = phase - 64'h8000_0000;
            neg   = 1'b1;
        end
        if (phase > 64'h4000_0000)
            phase = 64'h8000_0000 - phase;
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        z = longint'(phase);
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLE[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLE[k];
            end
        end
        if (y < 0)
            y = 0;
        shift = CORDIC_SCALE_BITS - (SAMPLE_BITS - 1);
        mag   = (y + (longint'(1) << (shift - 1))) >>> shift;
        mag   = clamp_q15(mag);
        return neg ? -mag : mag;
    endfunction

    function automatic sample_word_t predict_word(input logic [INDEX_BITS-1:0] idx);
        sample_word_t    w;
        longint unsigned size;
        longint unsigned i;
        longint          one;
        longint          ratio;
        longint          v;
        size = (cur_size > MAX_TABLE_SIZE) ? MAX_TABLE_SIZE : cur_size;
        i    = idx;
        one  = longint'(1) << (SAMPLE_BITS - 1);
        v    = 0;
        w.flag = 1'b0;
        if (i >= size)
        begin
            w.flag = 1'b1;
        end
        else
        begin
            case (cur_shape)
                SHAPE_SINE:
                    v = sine_cordic(i, size);
                SHAPE_SQUARE:
                    if (i == 0 || i == size - 1)
                        v = 0;
                    else if (i < size / 2)
                        v = one;
                    else
                        v = -one;
                SHAPE_SAW:
                begin
                    ratio = longint'((2 * longint'(one) * i + size / 2) / size);
                    v = one - ratio;
                end
                default:
                begin
                    ratio = longint'((4 * longint'(one) * i + size / 2) / size);
                    if (i <= size / 2)
                        v = -one + ratio;
                    else
                        v = 3 * one - ratio;
                end
            endcase
            v = clamp_q15(v);
        end
        w.value = SAMPLE_BITS'(v);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one index word: idle at random first, then hold start until the
    // word is taken, and queue its expected sample at the accepting edge.
    task automatic send_word(input logic [INDEX_BITS-1:0] idx);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start        = 1'b0;
            sample_index = INDEX_BITS'($urandom);
            @(negedge clk);
        end
        start        = 1'b1;
        sample_index = idx;
        do
            @(posedge clk);
        while (busy);
        expected_words.push_back(predict_word(idx));
    endtask

    // Drop start and hold off until every expected word has come back.
    task automatic settle_block();
        @(negedge clk);
        start = 1'b0;
        while (expected_words.size() != 0 || busy)
            @(negedge clk);
    endtask

    // Write one register while the block is idle and track it in the predictor.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == REG_WAVE_SHAPE)
            cur_shape = shape_t'(data[1:0]);
        else if (idx == REG_TABLE_SIZE)
            cur_size = data;
    endtask

    // Mostly in-range indexes, leaning on the edges of the table, some noise.
    function automatic logic [INDEX_BITS-1:0] pick_index();
        int unsigned eff;
        int unsigned r;
        eff = (cur_size > MAX_TABLE_SIZE) ? MAX_TABLE_SIZE : cur_size;
        r   = $urandom_range(0, 99);
        if (eff == 0 || r < 10)
            return INDEX_BITS'($urandom_range(0, 4095));
        if (r < 22)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return INDEX_BITS'(eff - 1);
                2:       return INDEX_BITS'(eff / 2);
                3:       return INDEX_BITS'((eff / 2 > 0) ? eff / 2 - 1 : 0);
                default: return INDEX_BITS'((eff / 2 + 1 < eff) ? eff / 2 + 1 : eff - 1);
            endcase
        end
        return INDEX_BITS'($urandom_range(0, eff - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Sine over 1024 entries straight out of reset, with both range flags.
    task automatic test_reset_values();
        send_word(12'd0);
        send_word(12'd256);
        send_word(12'd1023);
        send_word(12'd1024);
        send_word(12'd4095);
        settle_block();
    endtask

    // Every shape on a four-entry table: first and last entry for sine and saw,
    // and for square and triangle every entry, half-way point included.
    task automatic test_every_shape();
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(4));
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SINE));
        send_word(12'd0);
        send_word(12'd3);
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SAW));
        send_word(12'd0);
        send_word(12'd3);
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SQUARE));
        for (int i = 0; i < 4; i++)
            send_word(INDEX_BITS'(i));
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_TRIANGLE));
        for (int i = 0; i < 4; i++)
            send_word(INDEX_BITS'(i));
        settle_block();
    endtask

    // Empty, tiny, full and oversized tables, and writes to dead indexes.
    task automatic test_size_corners();
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(0));
        send_word(12'd0);
        send_word(12'd4095);
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SAW));
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(1));
        send_word(12'd0);
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_TRIANGLE));
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(3));
        send_word(12'd2);
        settle_block();
        // Oversized size acts as the maximum, so the top index is in range.
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SINE));
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(8191));
        send_word(12'd4095);
        settle_block();
        write_register(REG_WAVE_SHAPE, CFG_DATA_BITS'(SHAPE_SQUARE));
        write_register(REG_TABLE_SIZE, CFG_DATA_BITS'(MAX_TABLE_SIZE));
        send_word(12'd4095);
        settle_block();
        write_register(REG_UNUSED_2, '1);
        write_register(REG_UNUSED_3, '0);
        send_word(12'd4095);
        settle_block();
    endtask

    // Random settings, each followed by a burst of index words.
    task automatic test_random_traffic(input int idle_pct, input int word_total);
        int                   sent;
        int                   setting;
        int                   burst;
        logic [CFG_DATA_BITS-1:0] data;
        begin
            sender_idle_pct = idle_pct;
            sent    = 0;
            setting = 0;
            while (sent < word_total)
            begin
                settle_block();
                // Junk in the upper bits of the shape write must be ignored.
                data      = CFG_DATA_BITS'($urandom_range(0, 8191));
                data[1:0] = 2'(setting % 4);
                write_register(REG_WAVE_SHAPE, data);
                case ($urandom_range(0, 9))
                    0:       data = CFG_DATA_BITS'(MAX_TABLE_SIZE);
                    1:       data = CFG_DATA_BITS'(4);
                    2:       data = CFG_DATA_BITS'($urandom_range(0, 3));
                    3:       data = CFG_DATA_BITS'($urandom_range(MAX_TABLE_SIZE + 1, 8191));
                    default: data = CFG_DATA_BITS'($urandom_range(4, MAX_TABLE_SIZE));
                endcase
                write_register(REG_TABLE_SIZE, data);
                if ($urandom_range(0, 3) == 0)
                    write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                                   CFG_DATA_BITS'($urandom));
                burst = $urandom_range(30, 90);
                for (int n = 0; n < burst; n++)
                    send_word(pick_index());
                sent = sent + burst;
                setting++;
            end
            settle_block();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking: every done strobe is one result word, matched in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_word_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected word: sample %0d flag %0b",
                             sample_value, index_out_of_range);
            end
            else
            begin
                want = expected_words.pop_front();
                if (sample_value !== want.value || index_out_of_range !== want.flag)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: sample exp %0d got %0d, flag exp %0b got %0b",
                                 want.value, sample_value, want.flag, index_out_of_range);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_wavetable_sample_generator_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        sample_index = '0;
        cur_shape    = SHAPE_SINE;
        cur_size     = SIZE_BITS'(1024);

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 35;
        test_reset_values();
        test_every_shape();
        test_size_corners();

        // Sender idles lightly, then heavily, then drives back to back.
        test_random_traffic(35, WORDS_RANDOM / 3);
        test_random_traffic(73, WORDS_RANDOM / 3);
        test_random_traffic(0, WORDS_RANDOM - 2 * (WORDS_RANDOM / 3));

        // Drain past the longest latency, then flag any word never returned.
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected words never arrived", expected_words.size());
        end

        if (mismatch_count == 0)
            $display("tb_wavetable_sample_generator_top: done, clean");
        else
            $display("tb_wavetable_sample_generator_top: done, errors");
        $finish;
    end

endmodule

>>> wavetable_sample_generator_top.f
+incdir+hw/rtl
hw/rtl/wtsg_pkg.sv
hw/rtl/wtsg_div.sv
hw/rtl/wtsg_cordic.sv
hw/rtl/wavetable_sample_generator_top.sv
tb/sv/tb_wavetable_sample_generator_top.sv
